/* design/tcc_pkg.sv */
// ----------------------------------------------------------------------------
// tcc_pkg
// Widths, types and helpers shared by the triangle circumcentre pipeline.
// ----------------------------------------------------------------------------
package tcc_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 8;
    localparam int QW         = 32;

    localparam int CW    = COORD_BITS + 1;
    localparam int PW    = 2 * CW;
    localparam int CCW   = PW + 1;
    localparam int DETW  = PW + 1;
    localparam int DENW  = DETW + 1;
    localparam int PRW   = CW + CCW;
    localparam int NUMW  = PRW + 1;
    localparam int MAGW  = NUMW + FRAC_BITS;
    localparam int RW    = (MAGW > DENW + QW + 1) ? MAGW : DENW + QW + 1;
    localparam int FRONT_STAGES = 5;
    localparam int PIPE_STAGES  = FRONT_STAGES + QW;

    localparam logic [QW-1:0] QPOS_MAX = {1'b0, {(QW-1){1'b1}}};
    localparam logic [QW-1:0] QNEG_MAX = {1'b1, {(QW-1){1'b0}}};

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [CW-1:0]         cw_t;
    typedef logic signed [PW-1:0]         pw_t;
    typedef logic signed [CCW-1:0]        ccw_t;
    typedef logic signed [DETW-1:0]       detw_t;
    typedef logic signed [DENW-1:0]       denw_t;
    typedef logic signed [PRW-1:0]        prw_t;
    typedef logic signed [NUMW-1:0]       numw_t;

    typedef struct packed {
        logic [RW-1:0] rem;
        logic [RW-1:0] dsh;
        logic [QW-1:0] quot;
        logic          neg;
        logic          big;
    } div_t;

    typedef struct packed {
        div_t dx;
        div_t dy;
        logic collinear;
    } front_t;

    typedef struct packed {
        logic [QW-1:0] value;
        logic          ovf;
    } sat_t;

    function automatic sat_t saturate(div_t d);
        sat_t s;
        s.ovf   = 1'b0;
        s.value = d.quot;
        if (d.neg) begin
            if (d.big || (d.quot > QNEG_MAX)) begin
                s.ovf   = 1'b1;
                s.value = QNEG_MAX;
            end
            else begin
                s.value = ~d.quot + 1'b1;
            end
        end
        else if (d.big || (d.quot > QPOS_MAX)) begin
            s.ovf   = 1'b1;
            s.value = QPOS_MAX;
        end
        return s;
    endfunction

endpackage

/* design/tcc_front.sv */
// ----------------------------------------------------------------------------
// tcc_front
// Five-stage arithmetic front end: bisector lines, determinant, Cramer
// numerators, and the magnitudes and signs that seed the divider chains.
// ----------------------------------------------------------------------------
module tcc_front (
    input  logic                     clk,
    input  logic                     en,
    input  tcc_pkg::coord_t          p_x,
    input  tcc_pkg::coord_t          p_y,
    input  tcc_pkg::coord_t          q_x,
    input  tcc_pkg::coord_t          q_y,
    input  tcc_pkg::coord_t          r_x,
    input  tcc_pkg::coord_t          r_y,
    output tcc_pkg::front_t          front
);

    tcc_pkg::cw_t   a1_reg, b1_reg, a2_reg, b2_reg;
    tcc_pkg::cw_t   sx1_reg, sy1_reg, sx2_reg, sy2_reg;
    tcc_pkg::cw_t   a1_2_reg, b1_2_reg, a2_2_reg, b2_2_reg;
    tcc_pkg::pw_t   m1_reg, m2_reg, m3_reg, m4_reg, m5_reg, m6_reg;
    tcc_pkg::cw_t   a1_3_reg, b1_3_reg, a2_3_reg, b2_3_reg;
    tcc_pkg::ccw_t  c1_reg, c2_reg;
    tcc_pkg::detw_t det_reg, det_4_reg;
    tcc_pkg::prw_t  px1_reg, px2_reg, py1_reg, py2_reg;
    tcc_pkg::front_t front_reg;

    tcc_pkg::numw_t nx, ny;
    tcc_pkg::denw_t det2;
    logic [tcc_pkg::NUMW-1:0] nx_mag, ny_mag;
    logic [tcc_pkg::DENW-1:0] d_mag;
    logic [tcc_pkg::RW-1:0]   x_sh, y_sh, d_top;
    tcc_pkg::front_t front_next;

    always_comb
    begin
        nx     = tcc_pkg::numw_t'(px1_reg) - tcc_pkg::numw_t'(px2_reg);
        ny     = tcc_pkg::numw_t'(py1_reg) - tcc_pkg::numw_t'(py2_reg);
        det2   = {det_4_reg, 1'b0};
        nx_mag = nx[tcc_pkg::NUMW-1] ? (~nx + 1'b1) : nx;
        ny_mag = ny[tcc_pkg::NUMW-1] ? (~ny + 1'b1) : ny;
        d_mag  = det2[tcc_pkg::DENW-1] ? (~det2 + 1'b1) : det2;
        x_sh   = tcc_pkg::RW'(nx_mag) << tcc_pkg::FRAC_BITS;
        y_sh   = tcc_pkg::RW'(ny_mag) << tcc_pkg::FRAC_BITS;
        d_top  = tcc_pkg::RW'(d_mag) << tcc_pkg::QW;

        front_next.dx.rem  = x_sh;
        front_next.dx.dsh  = tcc_pkg::RW'(d_mag) << (tcc_pkg::QW - 1);
        front_next.dx.quot = '0;
        front_next.dx.neg  = nx[tcc_pkg::NUMW-1] ^ det2[tcc_pkg::DENW-1];
        front_next.dx.big  = (x_sh >= d_top);
        front_next.dy.rem  = y_sh;
        front_next.dy.dsh  = tcc_pkg::RW'(d_mag) << (tcc_pkg::QW - 1);
        front_next.dy.quot = '0;
        front_next.dy.neg  = ny[tcc_pkg::NUMW-1] ^ det2[tcc_pkg::DENW-1];
        front_next.dy.big  = (y_sh >= d_top);
        front_next.collinear = (det_4_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg  <= tcc_pkg::cw_t'(q_x) - tcc_pkg::cw_t'(p_x);
            b1_reg  <= tcc_pkg::cw_t'(q_y) - tcc_pkg::cw_t'(p_y);
            a2_reg  <= tcc_pkg::cw_t'(r_x) - tcc_pkg::cw_t'(q_x);
            b2_reg  <= tcc_pkg::cw_t'(r_y) - tcc_pkg::cw_t'(q_y);
            sx1_reg <= tcc_pkg::cw_t'(p_x) + tcc_pkg::cw_t'(q_x);
            sy1_reg <= tcc_pkg::cw_t'(p_y) + tcc_pkg::cw_t'(q_y);
            sx2_reg <= tcc_pkg::cw_t'(q_x) + tcc_pkg::cw_t'(r_x);
            sy2_reg <= tcc_pkg::cw_t'(q_y) + tcc_pkg::cw_t'(r_y);

            m1_reg <= tcc_pkg::pw_t'(a1_reg) * tcc_pkg::pw_t'(sx1_reg);
            m2_reg <= tcc_pkg::pw_t'(b1_reg) * tcc_pkg::pw_t'(sy1_reg);
            m3_reg <= tcc_pkg::pw_t'(a2_reg) * tcc_pkg::pw_t'(sx2_reg);
            m4_reg <= tcc_pkg::pw_t'(b2_reg) * tcc_pkg::pw_t'(sy2_reg);
            m5_reg <= tcc_pkg::pw_t'(a1_reg) * tcc_pkg::pw_t'(b2_reg);
            m6_reg <= tcc_pkg::pw_t'(a2_reg) * tcc_pkg::pw_t'(b1_reg);
            a1_2_reg <= a1_reg;
            b1_2_reg <= b1_reg;
            a2_2_reg <= a2_reg;
            b2_2_reg <= b2_reg;

            c1_reg  <= tcc_pkg::ccw_t'(m1_reg) + tcc_pkg::ccw_t'(m2_reg);
            c2_reg  <= tcc_pkg::ccw_t'(m3_reg) + tcc_pkg::ccw_t'(m4_reg);
            det_reg <= tcc_pkg::detw_t'(m5_reg) - tcc_pkg::detw_t'(m6_reg);
            a1_3_reg <= a1_2_reg;
            b1_3_reg <= b1_2_reg;
            a2_3_reg <= a2_2_reg;
            b2_3_reg <= b2_2_reg;

            px1_reg <= tcc_pkg::prw_t'(b2_3_reg) * tcc_pkg::prw_t'(c1_reg);
            px2_reg <= tcc_pkg::prw_t'(b1_3_reg) * tcc_pkg::prw_t'(c2_reg);
            py1_reg <= tcc_pkg::prw_t'(a1_3_reg) * tcc_pkg::prw_t'(c2_reg);
            py2_reg <= tcc_pkg::prw_t'(a2_3_reg) * tcc_pkg::prw_t'(c1_reg);
            det_4_reg <= det_reg;

            front_reg <= front_next;
        end
    end

    assign front = front_reg;

endmodule

/* design/tcc_div_cell.sv */
// ----------------------------------------------------------------------------
// tcc_div_cell
// One restoring division step: settles one quotient bit and hands the
// partial remainder and the halved divisor on to the next cell.
// ----------------------------------------------------------------------------
module tcc_div_cell (
    input  logic          clk,
    input  logic          en,
    input  tcc_pkg::div_t d_in,
    output tcc_pkg::div_t d_out
);

    tcc_pkg::div_t d_reg;
    tcc_pkg::div_t d_next;
    logic          take;

    always_comb
    begin
        take         = (d_in.rem >= d_in.dsh);
        d_next       = d_in;
        d_next.rem   = take ? (d_in.rem - d_in.dsh) : d_in.rem;
        d_next.dsh   = d_in.dsh >> 1;
        d_next.quot  = {d_in.quot[tcc_pkg::QW-2:0], take};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

/* design/triangle_circumcenter_top.sv */
// ----------------------------------------------------------------------------
// triangle_circumcenter_top
// Circumcentre of a triangle from the intersection of two perpendicular
// bisectors, with a chain of division cells for each coordinate.
//
//   Channel  Signals                      Direction  Contents
//   in       in_valid, in_stall, p..r     into block three vertices
//   out      out_valid, out_stall, centre out of     centre, collinear, overflow
//
// The path runs through five front-end stages, 32 division cells and one output
// register. One transaction is taken every cycle while the output is not held.
// Reset clears only the valid bits; no payload register is reset.
// A stalled output freezes the whole pipeline and stalls the input.
// ----------------------------------------------------------------------------
module triangle_circumcenter_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  tcc_pkg::coord_t               p_x,
    input  tcc_pkg::coord_t               p_y,
    input  tcc_pkg::coord_t               q_x,
    input  tcc_pkg::coord_t               q_y,
    input  tcc_pkg::coord_t               r_x,
    input  tcc_pkg::coord_t               r_y,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [tcc_pkg::QW-1:0] center_x,
    output logic signed [tcc_pkg::QW-1:0] center_y,
    output logic                          collinear,
    output logic                          overflow
);

    logic                 adv;
    tcc_pkg::front_t      front;
    tcc_pkg::div_t        cx [0:tcc_pkg::QW];
    tcc_pkg::div_t        cy [0:tcc_pkg::QW];
    logic [tcc_pkg::PIPE_STAGES-1:0] vld_reg, vld_next;
    logic [tcc_pkg::QW-1:0] col_reg, col_next;
    logic                 out_valid_reg, out_valid_next;
    logic [tcc_pkg::QW-1:0] cx_out_reg, cy_out_reg;
    logic                 col_out_reg, ovf_out_reg;
    tcc_pkg::sat_t        sx, sy;

    assign adv = !(out_valid_reg && out_stall);

    tcc_front u_front (
        .clk   (clk),
        .en    (adv),
        .p_x   (p_x),
        .p_y   (p_y),
        .q_x   (q_x),
        .q_y   (q_y),
        .r_x   (r_x),
        .r_y   (r_y),
        .front (front)
    );

    assign cx[0] = front.dx;
    assign cy[0] = front.dy;

    genvar gi;
    generate
        for (gi = 0; gi < tcc_pkg::QW; gi++)
        begin : g_chain
            tcc_div_cell u_cell_x (
                .clk   (clk),
                .en    (adv),
                .d_in  (cx[gi]),
                .d_out (cx[gi+1])
            );
            tcc_div_cell u_cell_y (
                .clk   (clk),
                .en    (adv),
                .d_in  (cy[gi]),
                .d_out (cy[gi+1])
            );
        end
    endgenerate

    always_comb
    begin
        vld_next       = vld_reg;
        col_next       = col_reg;
        out_valid_next = out_valid_reg;
        if (adv)
        begin
            vld_next       = {vld_reg[tcc_pkg::PIPE_STAGES-2:0], in_valid};
            col_next       = {col_reg[tcc_pkg::QW-2:0], front.collinear};
            out_valid_next = vld_reg[tcc_pkg::PIPE_STAGES-1];
        end
        sx = tcc_pkg::saturate(cx[tcc_pkg::QW]);
        sy = tcc_pkg::saturate(cy[tcc_pkg::QW]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            vld_reg       <= vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg <= col_next;
        if (adv)
        begin
            if (col_reg[tcc_pkg::QW-1])
            begin
                cx_out_reg  <= '0;
                cy_out_reg  <= '0;
                col_out_reg <= 1'b1;
                ovf_out_reg <= 1'b0;
            end
            else
            begin
                cx_out_reg  <= sx.value;
                cy_out_reg  <= sy.value;
                col_out_reg <= 1'b0;
                ovf_out_reg <= sx.ovf | sy.ovf;
            end
        end
    end

    assign in_stall  = !adv;
    assign out_valid = out_valid_reg;
    assign center_x  = cx_out_reg;
    assign center_y  = cy_out_reg;
    assign collinear = col_out_reg;
    assign overflow  = ovf_out_reg;

    a_col_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && collinear) |-> (center_x == '0 && center_y == '0 && !overflow))
        else $error("collinear result carries a non-zero centre");

    a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && overflow) |->
        (center_x == tcc_pkg::QPOS_MAX || center_x == tcc_pkg::QNEG_MAX ||
         center_y == tcc_pkg::QPOS_MAX || center_y == tcc_pkg::QNEG_MAX))
        else $error("overflow flagged without a saturated coordinate");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(vld_reg))
        else $error("pipeline moved while the output was held");

endmodule

/* tb/triangle_circumcenter_top_tb.sv */
// ----------------------------------------------------------------------------
// triangle_circumcenter_top_tb
// Streams triangles through the circumcentre pipeline and checks each centre,
// collinear flag and overflow flag against an exact wide-integer predictor.
// Both channels idle and stall at random in the first two of three phases.
// ----------------------------------------------------------------------------
module triangle_circumcenter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [tcc_pkg::QW-1:0] cx;
        logic signed [tcc_pkg::QW-1:0] cy;
        logic                          col;
        logic                          ovf;
    } centre_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    tcc_pkg::coord_t p_x = '0, p_y = '0, q_x = '0, q_y = '0, r_x = '0, r_y = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [tcc_pkg::QW-1:0] center_x, center_y;
    logic collinear, overflow;

    centre_t expected_centres[$];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int error_count = 0;
    int quiet_cycles = 0;

    triangle_circumcenter_top DUT (.*);

    always #4 clk = ~clk;

    function automatic logic signed [tcc_pkg::QW-1:0] saturate_quot(
        logic signed [127:0] num, logic signed [127:0] den, inout logic ovf);
        logic signed [127:0] q;
        q = (num <<< tcc_pkg::FRAC_BITS) / den;
        if (q > 128'sh7FFFFFFF) begin
            ovf = 1'b1;
            return 32'sh7FFFFFFF;
        end
        if (q < -128'sh80000000) begin
            ovf = 1'b1;
            return 32'sh80000000;
        end
        return q[tcc_pkg::QW-1:0];
    endfunction

    function automatic centre_t circumcentre(tcc_pkg::coord_t px, tcc_pkg::coord_t py,
                                             tcc_pkg::coord_t qx, tcc_pkg::coord_t qy,
                                             tcc_pkg::coord_t rx, tcc_pkg::coord_t ry);
        logic signed [127:0] a1, b1, c1, a2, b2, c2, det2;
        centre_t c;
        a1 = 128'(qx) - 128'(px);
        b1 = 128'(qy) - 128'(py);
        c1 = a1 * (128'(px) + 128'(qx)) + b1 * (128'(py) + 128'(qy));
        a2 = 128'(rx) - 128'(qx);
        b2 = 128'(ry) - 128'(qy);
        c2 = a2 * (128'(qx) + 128'(rx)) + b2 * (128'(qy) + 128'(ry));
        det2 = 128'sd2 * (a1 * b2 - a2 * b1);
        c.ovf = 1'b0;
        c.col = 1'b0;
        if (det2 == 0) begin
            c.cx = '0;
            c.cy = '0;
            c.col = 1'b1;
        end
        else begin
            c.cx = saturate_quot(b2 * c1 - b1 * c2, det2, c.ovf);
            c.cy = saturate_quot(a1 * c2 - a2 * c1, det2, c.ovf);
        end
        return c;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("ERROR at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic send_triangle(tcc_pkg::coord_t px, tcc_pkg::coord_t py,
                                 tcc_pkg::coord_t qx, tcc_pkg::coord_t qy,
                                 tcc_pkg::coord_t rx, tcc_pkg::coord_t ry);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        p_x <= px;
        p_y <= py;
        q_x <= qx;
        q_y <= qy;
        r_x <= rx;
        r_y <= ry;
        do
            @(posedge clk);
        while (in_stall);
        expected_centres.push_back(circumcentre(px, py, qx, qy, rx, ry));
    endtask

    always @(posedge clk) begin
        out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk) begin
        centre_t e;
        if (out_valid && !out_stall) begin
            if (expected_centres.size() == 0) begin
                report_mismatch("unexpected transaction, centre_x", center_x, 0);
            end
            else begin
                e = expected_centres.pop_front();
                if (center_x !== e.cx) report_mismatch("centre_x", center_x, e.cx);
                if (center_y !== e.cy) report_mismatch("centre_y", center_y, e.cy);
                if (collinear !== e.col) report_mismatch("collinear", collinear, e.col);
                if (overflow !== e.ovf) report_mismatch("overflow", overflow, e.ovf);
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 5000) begin
            $display("triangle_circumcenter_top verification failed");
            $finish;
        end
    end

    task automatic test_directed();
        send_triangle(0, 0, 256, 0, 0, 256);
        send_triangle(-32768, -32768, 32767, -32768, -32768, 32767);
        send_triangle(32767, 32767, -32768, 32767, 32767, -32768);
        send_triangle(-32768, -32768, 32767, 32767, -32768, 32767);
        send_triangle(0, 0, 10, 10, 20, 20);
        send_triangle(5, 5, 5, 5, 5, 5);
        send_triangle(1, 2, 1, 2, 300, -7);
        send_triangle(-32768, -32768, 0, 0, 32767, 32767);
        send_triangle(-32768, -32768, 32767, 32767, 32767, 32766);
        send_triangle(32767, -32768, -32768, 32767, -32767, 32767);
        send_triangle(0, 0, 1, 0, 0, 1);
        send_triangle(0, 0, -1, 0, 0, -1);
        send_triangle(-32768, 0, 32767, 0, 0, 1);
        send_triangle(0, -32768, 0, 32767, 1, 0);
        send_triangle(-32768, 0, 32767, 0, 0, -1);
        send_triangle(-1, -1, -1, -1, -1, -1);
        send_triangle(3, -4, -4, 3, 100, 100);
    endtask

    task automatic test_random(int count);
        tcc_pkg::coord_t px, py, qx, qy, rx, ry;
        int k;
        repeat (count) begin
            px = tcc_pkg::coord_t'($urandom);
            py = tcc_pkg::coord_t'($urandom);
            qx = tcc_pkg::coord_t'($urandom);
            qy = tcc_pkg::coord_t'($urandom);
            rx = tcc_pkg::coord_t'($urandom);
            ry = tcc_pkg::coord_t'($urandom);
            case ($urandom_range(3))
                1: begin
                    px = tcc_pkg::coord_t'($signed($urandom_range(64)) - 32);
                    py = tcc_pkg::coord_t'($signed($urandom_range(64)) - 32);
                    qx = tcc_pkg::coord_t'($signed($urandom_range(64)) - 32);
                    qy = tcc_pkg::coord_t'($signed($urandom_range(64)) - 32);
                    rx = tcc_pkg::coord_t'($signed($urandom_range(64)) - 32);
                    ry = tcc_pkg::coord_t'($signed($urandom_range(64)) - 32);
                end
                2: begin
                    px = tcc_pkg::coord_t'($signed($urandom_range(2000)) - 1000);
                    py = tcc_pkg::coord_t'($signed($urandom_range(2000)) - 1000);
                    qx = tcc_pkg::coord_t'(px + $signed($urandom_range(20)) - 10);
                    qy = tcc_pkg::coord_t'(py + $signed($urandom_range(20)) - 10);
                    k = $signed($urandom_range(40)) - 20;
                    rx = tcc_pkg::coord_t'(px + k * (qx - px) +
                                           $signed($urandom_range(2)) - 1);
                    ry = tcc_pkg::coord_t'(py + k * (qy - py) +
                                           $signed($urandom_range(2)) - 1);
                end
                3: begin
                    if ($urandom_range(1)) begin
                        qx = px;
                        qy = py;
                    end
                    else begin
                        rx = qx;
                        ry = qy;
                    end
                end
                default: ;
            endcase
            send_triangle(px, py, qx, qy, rx, ry);
        end
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_pct = 22;
        recv_stall_pct = 58;
        test_directed();
        test_random(280);
        send_idle_pct = 58;
        recv_stall_pct = 22;
        test_random(280);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random(290);
        in_valid <= 1'b0;
        while (expected_centres.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (error_count == 0)
            $display("triangle_circumcenter_top verification clean");
        else
            $display("triangle_circumcenter_top verification failed");
        $finish;
    end
endmodule

/* triangle_circumcenter_top.f */
design/tcc_pkg.sv
design/tcc_front.sv
design/tcc_div_cell.sv
design/triangle_circumcenter_top.sv
tb/triangle_circumcenter_top_tb.sv
